@@ hw/rtl/nearest_point_within_radius_defines.svh @@
// assertion macros for the nearest point within radius block
`ifndef NEAREST_POINT_WITHIN_RADIUS_DEFINES_SVH
`define NEAREST_POINT_WITHIN_RADIUS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define NPWR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define NPWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/npwr_pkg.sv @@
// shared types, constants and helpers for the nearest point within radius block
`default_nettype none

package npwr_pkg;

    // field widths
    localparam int COORD_W      = 16;
    localparam int RADIUS_W     = 16;
    localparam int ENTRY_W      = 6;
    localparam int SQ_W         = 32;
    localparam int DIST_W       = 34;

    // defaults
    localparam int MAX_POINTS_DEF = 8;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;

    // request opcodes
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    // which result the datapath captures
    typedef enum logic [1:0] {
        RES_ADD_OK,
        RES_FULL,
        RES_QUERY
    } res_kind_t;

    // controller to datapath commands
    typedef struct packed {
        logic      load_query;
        logic      clear_best;
        logic      rd_en;
        logic      wr_en;
        logic      res_load;
        res_kind_t res_kind;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic pipe_busy;
    } status_t;

    // magnitude of the difference of two signed coordinates
    function automatic logic [COORD_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic [COORD_W:0] d;
        logic [COORD_W:0] m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/npwr_if.sv @@
// request and result channel interfaces
`default_nettype none

interface npwr_req_if;
    logic                         valid;
    logic                         ready;
    logic                         op;
    logic [npwr_pkg::COORD_W-1:0] pos_x;
    logic [npwr_pkg::COORD_W-1:0] pos_y;
    logic [npwr_pkg::COORD_W-1:0] pos_z;

    modport source (output valid, op, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, op, pos_x, pos_y, pos_z, output ready);
endinterface

interface npwr_res_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic [npwr_pkg::ENTRY_W-1:0] entry_index;
    logic                         table_full;

    modport source (output valid, hit, entry_index, table_full, input ready);
    modport sink   (input valid, hit, entry_index, table_full, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/npwr_datapath.sv @@
// point table, distance pipeline, best tracker and result register
`default_nettype none

module npwr_datapath #(
    parameter int MAX_POINTS = npwr_pkg::MAX_POINTS_DEF,
    parameter int IDX_W      = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [npwr_pkg::RADIUS_W-1:0] cfg_wr_data,
    input  logic [npwr_pkg::COORD_W-1:0]  pos_x,
    input  logic [npwr_pkg::COORD_W-1:0]  pos_y,
    input  logic [npwr_pkg::COORD_W-1:0]  pos_z,
    input  npwr_pkg::cmd_t                cmd,
    input  logic [IDX_W-1:0]              rd_addr,
    input  logic [IDX_W-1:0]              wr_addr,
    output npwr_pkg::status_t             status,
    output logic                          hit,
    output logic [npwr_pkg::ENTRY_W-1:0]  entry_index,
    output logic                          table_full
);
    import npwr_pkg::*;

    // point table
    logic [COORD_W-1:0] mem_x [MAX_POINTS];
    logic [COORD_W-1:0] mem_y [MAX_POINTS];
    logic [COORD_W-1:0] mem_z [MAX_POINTS];

    logic [RADIUS_W-1:0] radius_reg;
    logic [SQ_W-1:0]     r2_reg;

    logic [COORD_W-1:0] q_x_reg, q_y_reg, q_z_reg;

    // pipeline payload
    logic [COORD_W-1:0] rd_x_reg, rd_y_reg, rd_z_reg;
    logic [COORD_W-1:0] d_x_reg, d_y_reg, d_z_reg;
    logic [SQ_W-1:0]    sq_x_reg, sq_y_reg, sq_z_reg;
    logic [DIST_W-1:0]  sum_reg;
    logic [IDX_W-1:0]   tag1_reg, tag2_reg, tag3_reg, tag4_reg;

    // pipeline valids
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // best so far
    logic              found_reg;
    logic [DIST_W-1:0] best_reg;
    logic [IDX_W-1:0]  best_idx_reg;

    // result register
    logic               hit_reg;
    logic [ENTRY_W-1:0] idx_reg;
    logic               full_reg;

    logic better;
    logic query_hit;

    // radius register and its square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            r2_reg     <= SQ_W'(RADIUS_RESET) * SQ_W'(RADIUS_RESET);
        end
        else
        begin
            if (cfg_wr_en)
            begin
                radius_reg <= cfg_wr_data;
            end
            r2_reg <= SQ_W'(radius_reg) * SQ_W'(radius_reg);
        end
    end

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_x[wr_addr] <= q_x_reg;
            mem_y[wr_addr] <= q_y_reg;
            mem_z[wr_addr] <= q_z_reg;
        end
        if (cmd.rd_en)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
            rd_z_reg <= mem_z[rd_addr];
        end
    end

    // request capture and distance stages
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            q_x_reg <= pos_x;
            q_y_reg <= pos_y;
            q_z_reg <= pos_z;
        end
        tag1_reg <= rd_addr;
        tag2_reg <= tag1_reg;
        tag3_reg <= tag2_reg;
        tag4_reg <= tag3_reg;
        d_x_reg  <= abs_diff(rd_x_reg, q_x_reg);
        d_y_reg  <= abs_diff(rd_y_reg, q_y_reg);
        d_z_reg  <= abs_diff(rd_z_reg, q_z_reg);
        sq_x_reg <= SQ_W'(d_x_reg) * SQ_W'(d_x_reg);
        sq_y_reg <= SQ_W'(d_y_reg) * SQ_W'(d_y_reg);
        sq_z_reg <= SQ_W'(d_z_reg) * SQ_W'(d_z_reg);
        sum_reg  <= DIST_W'(sq_x_reg) + DIST_W'(sq_y_reg) + DIST_W'(sq_z_reg);
    end

    // valid shift line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // strict less keeps the lower index on ties
    assign better = v4_reg && (!found_reg || (sum_reg < best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.clear_best)
        begin
            found_reg <= 1'b0;
        end
        else if (better)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (better)
        begin
            best_reg     <= sum_reg;
            best_idx_reg <= tag4_reg;
        end
    end

    assign query_hit = found_reg && (best_reg < DIST_W'(r2_reg));

    // result capture
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            unique case (cmd.res_kind)
                RES_ADD_OK:
                begin
                    hit_reg  <= 1'b1;
                    idx_reg  <= ENTRY_W'(wr_addr);
                    full_reg <= 1'b0;
                end
                RES_FULL:
                begin
                    hit_reg  <= 1'b0;
                    idx_reg  <= '0;
                    full_reg <= 1'b1;
                end
                RES_QUERY:
                begin
                    hit_reg  <= query_hit;
                    idx_reg  <= query_hit ? ENTRY_W'(best_idx_reg) : '0;
                    full_reg <= 1'b0;
                end
                default:
                begin
                    hit_reg  <= 1'b0;
                    idx_reg  <= '0;
                    full_reg <= 1'b0;
                end
            endcase
        end
    end

    assign status.pipe_busy = v1_reg | v2_reg | v3_reg | v4_reg;
    assign hit              = hit_reg;
    assign entry_index      = idx_reg;
    assign table_full       = full_reg;

endmodule

`default_nettype wire

@@ hw/rtl/npwr_ctrl.sv @@
// controller: request handshake, table fill count, scan sequencing, result valid
`default_nettype none

module npwr_ctrl #(
    parameter int MAX_POINTS = npwr_pkg::MAX_POINTS_DEF,
    parameter int IDX_W      = 3,
    parameter int CNT_W      = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_op,
    output logic              req_ready,
    output logic              res_valid,
    input  logic              res_ready,
    input  npwr_pkg::status_t status,
    output npwr_pkg::cmd_t    cmd,
    output logic [IDX_W-1:0]  rd_addr,
    output logic [IDX_W-1:0]  wr_addr
);
    import npwr_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic             res_valid_reg, res_valid_next;

    logic accept;
    logic out_free;
    logic has_room;
    logic scan_more;

    assign accept    = req_valid && req_ready;
    assign out_free  = !res_valid_reg || res_ready;
    assign has_room  = count_reg < CNT_W'(MAX_POINTS);
    assign scan_more = scan_reg < count_reg;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_op == OP_QUERY) ? ST_SCAN : ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!scan_more)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs, commands and counters
    always_comb
    begin
        cmd            = '0;
        cmd.res_kind   = RES_QUERY;
        req_ready      = 1'b0;
        count_next     = count_reg;
        scan_next      = scan_reg;
        res_valid_next = res_valid_reg && !res_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                // ready is high here, so a valid request is taken
                req_ready      = 1'b1;
                cmd.load_query = req_valid;
                cmd.clear_best = req_valid;
                if (req_valid)
                begin
                    scan_next = '0;
                end
            end
            ST_ADD:
            begin
                if (out_free)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_kind   = has_room ? RES_ADD_OK : RES_FULL;
                    cmd.wr_en      = has_room;
                    res_valid_next = 1'b1;
                    if (has_room)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                // one stored entry issued per cycle
                if (scan_more)
                begin
                    cmd.rd_en = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_kind   = RES_QUERY;
                    res_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rd_addr   = scan_reg[IDX_W-1:0];
    assign wr_addr   = count_reg[IDX_W-1:0];
    assign res_valid = res_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/nearest_point_within_radius.sv @@
// Nearest point within radius, top level.
//
// Requests arrive on the item channel (valid/ready): op 0 appends a Q8.8
// location to the point table, op 1 queries the nearest stored location.
// Each request gives exactly one result on the result channel (valid/ready):
// hit, entry_index and table_full. The user must write the hit radius
// through cfg_wr_en / cfg_wr_data while the block is idle (not enforced).
//
// An add goes from idle to the add state, where its result is captured. A
// query goes from idle through the scan and drain states to the result
// state: the scan reads one entry per cycle from the point table into a
// four-stage distance pipeline (difference, square, sum, best compare),
// which then drains before the result is captured. Requests are handled
// one at a time; the next request is taken once the current result sits
// in the output register.
//
// Reset empties the table and sets the radius to 1.0 (256). If the receiver
// stalls, the result is held in the output register and the block stops
// before capturing the following result.
`default_nettype none

module nearest_point_within_radius #(
    parameter int MAX_POINTS = npwr_pkg::MAX_POINTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    npwr_req_if.sink                      item,
    npwr_res_if.source                    result,
    input  logic                          cfg_wr_en,
    input  logic [npwr_pkg::RADIUS_W-1:0] cfg_wr_data
);
    import npwr_pkg::*;

    `include "nearest_point_within_radius_defines.svh"

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    cmd_t             cmd;
    status_t          status;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    // controller
    npwr_ctrl #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (item.valid),
        .req_op    (item.op),
        .req_ready (item.ready),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .status    (status),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr)
    );

    // datapath
    npwr_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .IDX_W      (IDX_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .pos_x       (item.pos_x),
        .pos_y       (item.pos_y),
        .pos_z       (item.pos_z),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .wr_addr     (wr_addr),
        .status      (status),
        .hit         (result.hit),
        .entry_index (result.entry_index),
        .table_full  (result.table_full)
    );

    // checks
    `NPWR_ASSERT_NEXT(a_one_request_at_a_time, clk, rst_n, item.valid && item.ready, !item.ready, "request taken while another is in progress")
    `NPWR_ASSERT_NOW(a_no_result_overwrite, clk, rst_n, cmd.res_load, !result.valid || result.ready, "result register overwritten before it was taken")
    `NPWR_ASSERT_NOW(a_full_means_miss, clk, rst_n, result.valid && result.table_full, !result.hit && (result.entry_index == '0), "rejected add reports a hit or an index")
    `NPWR_ASSERT_NOW(a_no_read_during_write, clk, rst_n, cmd.wr_en, !cmd.rd_en && !status.pipe_busy, "table written while a scan is running")

endmodule

`default_nettype wire
